// ===== hw/rtl/rc_ptm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_ptm_pkg
// shared widths, register indexes, channel state type and per-tick helpers
// for the rc pulse tank mixer
// ----------------------------------------------------------------------------
package rc_ptm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int WIDTH_BITS = 16;
    localparam int DB_BITS    = 10;
    localparam int WIDE_BITS  = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;
    localparam int MIX_BITS   = WIDE_BITS + 3;
    localparam int IN_BYTES   = 1;
    localparam int OUT_BITS   = 2 * WIDTH_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    localparam logic [WIDTH_BITS-1:0] CENTER_RST  = WIDTH_BITS'(1500);
    localparam logic [DB_BITS-1:0]    DEADBAND_RST = DB_BITS'(25);
    localparam logic [WIDTH_BITS-1:0] OUT_MIN_RST = WIDTH_BITS'(1000);
    localparam logic [WIDTH_BITS-1:0] OUT_MAX_RST = WIDTH_BITS'(2000);

    typedef enum logic [1:0] {
        CFG_CENTER_WIDTH = 2'd0,
        CFG_DEADBAND     = 2'd1,
        CFG_OUTPUT_MIN   = 2'd2,
        CFG_OUTPUT_MAX   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                  prev;
        logic                  active;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] pulse;
    } chan_t;

    // edge detect, saturating count and capture on the falling edge
    function automatic chan_t chan_tick(input chan_t ch, input logic lv);
        chan_t nx;
        nx = ch;
        if (lv && !ch.prev)
        begin
            nx.active = 1'b1;
            nx.count  = '0;
        end
        else if (ch.active)
        begin
            if (ch.count != COUNT_TOP)
            begin
                nx.count = ch.count + 1'b1;
            end
            if (!lv && ch.prev)
            begin
                nx.pulse  = nx.count;
                nx.active = 1'b0;
            end
        end
        nx.prev = lv;
        return nx;
    endfunction

    // widths closer to centre than the deadband snap to centre
    function automatic logic [WIDE_BITS-1:0] snap(
        input logic [COUNT_BITS-1:0] w,
        input logic [WIDTH_BITS-1:0] c,
        input logic [DB_BITS-1:0]    db
    );
        logic signed [WIDE_BITS:0] d;
        logic        [WIDE_BITS:0] mag;
        d   = $signed({1'b0, WIDE_BITS'(w)}) - $signed({1'b0, WIDE_BITS'(c)});
        mag = d[WIDE_BITS] ? (WIDE_BITS+1)'(-d) : (WIDE_BITS+1)'(d);
        return (mag < (WIDE_BITS+1)'(db)) ? WIDE_BITS'(c) : WIDE_BITS'(w);
    endfunction

endpackage

// ===== hw/rtl/rc_pulse_tank_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_tank_mixer_core
// rc receiver pulse capture for throttle and yaw with a tank drive mixer
// ----------------------------------------------------------------------------
// usage
// s_axis carries one microsecond tick per transaction: the throttle pin level
// in tdata bit 0 and the yaw pin level in bit 1. every tick gives exactly one
// m_axis transaction with the left width in tdata[15:0] and the right width
// in tdata[31:16], after deadband, mix and clamp.
// the block takes one tick every clock while s_tready is high. a tick's
// result reaches m_axis through three registered stages in order: the pulse
// capture, the deadband snap, then the mix and clamp into the result register.
// when m_axis stalls the three stages fill and s_tready falls; it rises again
// in the cycle the result register is taken.
// reset clears the capture state (widths read as zero), empties the pipeline
// and loads the register defaults: centre 1500, deadband 25, limits 1000 and
// 2000. the cfg port writes register cfg_index with cfg_data on any clock at
// which cfg_we is high; write only while no tick is in flight.
// ----------------------------------------------------------------------------
module rc_pulse_tank_mixer_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rc_ptm_pkg::IN_BYTES*8-1:0]    s_tdata,   // throttle_level, yaw_level
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rc_ptm_pkg::OUT_BITS-1:0]      m_tdata,   // left_width, right_width
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [rc_ptm_pkg::WIDTH_BITS-1:0]    cfg_data
);
    import rc_ptm_pkg::*;

    logic [WIDTH_BITS-1:0] center_reg;
    logic [DB_BITS-1:0]    deadband_reg;
    logic [WIDTH_BITS-1:0] out_min_reg;
    logic [WIDTH_BITS-1:0] out_max_reg;

    chan_t thr_reg, thr_next;
    chan_t yaw_reg, yaw_next;

    logic                  cap_valid_reg;
    logic                  snap_valid_reg;
    logic                  out_valid_reg;
    logic [WIDE_BITS-1:0]  t_snap_reg;
    logic [WIDE_BITS-1:0]  y_snap_reg;
    logic [WIDTH_BITS-1:0] left_reg, left_next;
    logic [WIDTH_BITS-1:0] right_reg, right_next;

    logic in_fire;
    logic snap_adv;
    logic out_adv;

    logic signed [MIX_BITS-1:0] left_sum;
    logic signed [MIX_BITS-1:0] right_sum;

    function automatic logic [WIDTH_BITS-1:0] clamp_out(
        input logic signed [MIX_BITS-1:0] x,
        input logic [WIDTH_BITS-1:0]      lo,
        input logic [WIDTH_BITS-1:0]      hi
    );
        logic signed [MIX_BITS-1:0] lo_s;
        logic signed [MIX_BITS-1:0] hi_s;
        lo_s = $signed(MIX_BITS'(lo));
        hi_s = $signed(MIX_BITS'(hi));
        if (x < lo_s)
        begin
            return lo;
        end
        if (x > hi_s)
        begin
            return hi;
        end
        return x[WIDTH_BITS-1:0];
    endfunction

    // handshake and pipeline advance
    assign out_adv  = out_valid_reg ? m_tready : 1'b1;
    assign snap_adv = snap_valid_reg && out_adv;
    assign s_tready = !cap_valid_reg || !snap_valid_reg || out_adv;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_reg, left_reg};

    always_comb
    begin
        thr_next = chan_tick(thr_reg, s_tdata[0]);
        yaw_next = chan_tick(yaw_reg, s_tdata[1]);
    end

    always_comb
    begin
        left_sum   = $signed(MIX_BITS'(t_snap_reg)) + $signed(MIX_BITS'(y_snap_reg))
                   - $signed(MIX_BITS'(center_reg));
        right_sum  = $signed(MIX_BITS'(t_snap_reg)) - $signed(MIX_BITS'(y_snap_reg))
                   + $signed(MIX_BITS'(center_reg));
        left_next  = clamp_out(left_sum, out_min_reg, out_max_reg);
        right_next = clamp_out(right_sum, out_min_reg, out_max_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg   <= CENTER_RST;
            deadband_reg <= DEADBAND_RST;
            out_min_reg  <= OUT_MIN_RST;
            out_max_reg  <= OUT_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CENTER_WIDTH: center_reg   <= cfg_data;
                CFG_DEADBAND:     deadband_reg <= cfg_data[DB_BITS-1:0];
                CFG_OUTPUT_MIN:   out_min_reg  <= cfg_data;
                CFG_OUTPUT_MAX:   out_max_reg  <= cfg_data;
                default:          center_reg   <= center_reg;
            endcase
        end
    end

    // capture state and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= '0;
            yaw_reg        <= '0;
            cap_valid_reg  <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                thr_reg <= thr_next;
                yaw_reg <= yaw_next;
            end
            if (in_fire)
            begin
                cap_valid_reg <= 1'b1;
            end
            else if (!snap_valid_reg || snap_adv)
            begin
                cap_valid_reg <= 1'b0;
            end
            if (!snap_valid_reg || snap_adv)
            begin
                snap_valid_reg <= cap_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= snap_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (cap_valid_reg && (!snap_valid_reg || snap_adv))
        begin
            t_snap_reg <= snap(thr_reg.pulse, center_reg, deadband_reg);
            y_snap_reg <= snap(yaw_reg.pulse, center_reg, deadband_reg);
        end
        if (snap_adv)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule
